>>> rtl/core/mtch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtch_pkg - shared types and constants of the compass heading core
// Field widths, register map codes, pipeline lane types and the arctangent
// table used by both CORDIC sections.
// ----------------------------------------------------------------------------
package mtch_pkg;

    localparam int RAW_W     = 16;
    localparam int ANG_W     = 17;
    localparam int NORM_W    = 19;
    localparam int HEAD_W    = 17;
    localparam int NORM_FRAC = 14;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 80;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int NUM_REGS  = 6;

    // normalizer datapath
    localparam int NUM_W  = 19;          // 2*t - max - min
    localparam int DEN_W  = 17;          // max - min
    localparam int DVS_W  = 18;          // 2*|den|
    localparam int DIV_QB = NORM_W;      // quotient bits kept before saturation
    localparam int REM_W  = 37;

    // CORDIC datapaths
    localparam int CW     = 32;          // sine/cosine lanes, Q30
    localparam int CQ     = 30;
    localparam int ZW     = 32;          // angles, degrees * 2^20
    localparam int VW     = 54;          // horizontal components, Q44
    localparam int DEG_SH = 20;
    localparam int ATAN_LEN = 24;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [ZW-1:0] DEG_180     = 32'sd188743680;

    localparam logic signed [NORM_W-1:0] NORM_MAX = 19'sd262143;
    localparam logic signed [NORM_W-1:0] NORM_MIN = -19'sd262144;
    localparam logic [DIV_QB-1:0]        POS_LIM  = 19'd262143;
    localparam logic [DIV_QB-1:0]        NEG_LIM  = 19'd262144;

    typedef enum logic [2:0] {
        REG_X_MIN = 3'd0,
        REG_X_MAX = 3'd1,
        REG_Y_MIN = 3'd2,
        REG_Y_MAX = 3'd3,
        REG_Z_MIN = 3'd4,
        REG_Z_MAX = 3'd5
    } reg_idx_t;

    localparam logic signed [RAW_W-1:0] CAL_RESET [NUM_REGS] = '{
        16'sd1200, 16'sd2100, 16'sd1200, 16'sd1900, 16'sd4900, 16'sd5600
    };

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DVS_W-1:0]  dvs;
        logic [DIV_QB-1:0] quo;
        logic              ovf;
        logic              neg;
    } div_lane_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } rot_lane_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } vec_lane_t;

    // x in the low bits, as on the result bus
    typedef struct packed {
        logic signed [NORM_W-1:0] z;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] x;
    } norm_t;

    // atan(2^-i) in degrees * 2^20
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 32'sd47185920;
            1:       v = 32'sd27855475;
            2:       v = 32'sd14718068;
            3:       v = 32'sd7471121;
            4:       v = 32'sd3750059;
            5:       v = 32'sd1876857;
            6:       v = 32'sd938658;
            7:       v = 32'sd469357;
            8:       v = 32'sd234682;
            9:       v = 32'sd117342;
            10:      v = 32'sd58671;
            11:      v = 32'sd29335;
            12:      v = 32'sd14668;
            13:      v = 32'sd7334;
            14:      v = 32'sd3667;
            15:      v = 32'sd1833;
            16:      v = 32'sd917;
            17:      v = 32'sd458;
            18:      v = 32'sd229;
            19:      v = 32'sd115;
            20:      v = 32'sd57;
            21:      v = 32'sd29;
            22:      v = 32'sd14;
            23:      v = 32'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/magnetometer_tilt_compensated_heading_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_tilt_compensated_heading_core - tilt compensated compass
// Normalizes the three magnetometer axes against their calibration window,
// rotates the field into the horizontal plane and takes its heading.
// The 19-step restoring divider and the two CORDIC chains set the
// depth of the pipeline.
// Throughput: one word per cycle; the whole pipe holds when the output waits.
// Reset: synchronous, active low; clears the valid bits and loads the
// calibration registers with their default window.
// ----------------------------------------------------------------------------
module magnetometer_tilt_compensated_heading_core
    import mtch_pkg::*;
#(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // raw_x, raw_y, raw_z, roll_angle, pitch_angle, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // norm_x, norm_y, norm_z, heading, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int NSTG      = DIV_QB + 2*CORDIC_STAGES + 10;
    localparam int FULL_A    = 360 * (2 ** ANGLE_FRAC_BITS);
    localparam int HALF_A    = FULL_A / 2;
    localparam int QUARTER_A = FULL_A / 4;
    localparam int ZSH       = DEG_SH - ANGLE_FRAC_BITS;
    localparam int AZW       = 24;
    localparam int MODW      = 32;
    localparam int MOD_STEPS = 6;
    localparam int M_PAD     = M_TDATA_W - 3*NORM_W - HEAD_W;

    // ------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------
    logic signed [RAW_W-1:0] cal_reg [NUM_REGS];
    reg_idx_t                cfg_idx;
    logic                    cfg_hit;

    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg_hit = cfg_idx inside {[REG_X_MIN:REG_Z_MAX]};
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {{(APB_DW-RAW_W){1'b0}}, cal_reg[cfg_idx]} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) cal_reg[i] <= CAL_RESET[i];
        end else if (psel && penable && pwrite && cfg_hit) begin
            cal_reg[cfg_idx] <= pwdata[RAW_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together
    // ------------------------------------------------------------------
    logic             adv;
    logic [NSTG-1:0]  vld_reg;

    assign adv      = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: numerator / denominator, angle folded modulo a full turn
    // ------------------------------------------------------------------
    logic signed [RAW_W:0]   t_in [3];
    logic signed [ANG_W-1:0] a_in [2];

    assign t_in[0] = {s_tdata[15], s_tdata[15:0]};
    assign t_in[1] = -{s_tdata[31], s_tdata[31:16]};   // Y flipped first
    assign t_in[2] = {s_tdata[47], s_tdata[47:32]};
    assign a_in[0] = s_tdata[64:48];
    assign a_in[1] = s_tdata[81:65];

    logic signed [NUM_W-1:0] num1_next [3];
    logic signed [DEN_W-1:0] den1_next [3];
    logic signed [NUM_W-1:0] num1_reg  [3];
    logic signed [DEN_W-1:0] den1_reg  [3];

    logic [ANG_W-1:0] amod1_next [2];
    logic [ANG_W-1:0] amod1_reg  [2];
    logic             asgn1_reg  [2];

    for (genvar g = 0; g < 3; g++) begin : g_ax1
        logic signed [RAW_W-1:0] lo;
        logic signed [RAW_W-1:0] hi;
        assign lo = cal_reg[2*g];
        assign hi = cal_reg[2*g+1];
        always_comb begin
            if (hi == lo) begin
                // flat window: unit scale on the offset
                num1_next[g] = NUM_W'(t_in[g]) - NUM_W'(lo);
                den1_next[g] = DEN_W'(1);
            end else begin
                num1_next[g] = (NUM_W'(t_in[g]) <<< 1) - NUM_W'(hi) - NUM_W'(lo);
                den1_next[g] = DEN_W'(hi) - DEN_W'(lo);
            end
        end
    end

    for (genvar h = 0; h < 2; h++) begin : g_an1
        always_comb begin
            logic [ANG_W-1:0] r;
            r = a_in[h][ANG_W-1] ? ANG_W'(-a_in[h]) : ANG_W'(a_in[h]);
            for (int j = MOD_STEPS - 1; j >= 0; j--) begin
                if (MODW'(r) >= (MODW'(FULL_A) << j))
                    r = ANG_W'(MODW'(r) - (MODW'(FULL_A) << j));
            end
            amod1_next[h] = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int g = 0; g < 3; g++) begin
                num1_reg[g] <= num1_next[g];
                den1_reg[g] <= den1_next[g];
            end
            for (int h = 0; h < 2; h++) begin
                amod1_reg[h] <= amod1_next[h];
                asgn1_reg[h] <= a_in[h][ANG_W-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: magnitudes for the divider, angle to [-90,90] plus flip
    // ------------------------------------------------------------------
    logic [REM_W-1:0]        n2_next   [3];
    logic [DVS_W-1:0]        d2_next   [3];
    logic                    neg2_next [3];
    logic [REM_W-1:0]        n2_reg    [3];
    logic [DVS_W-1:0]        d2_reg    [3];
    logic                    neg2_reg  [3];
    logic signed [AZW-1:0]   za2_next  [2];
    logic                    flip2_next[2];
    logic signed [AZW-1:0]   za2_reg   [2];
    logic                    flip2_reg [2];

    for (genvar g = 0; g < 3; g++) begin : g_ax2
        always_comb begin
            logic [NUM_W-1:0] nmag;
            logic [DEN_W-1:0] dmag;
            nmag = num1_reg[g][NUM_W-1] ? NUM_W'(-num1_reg[g]) : NUM_W'(num1_reg[g]);
            dmag = den1_reg[g][DEN_W-1] ? DEN_W'(-den1_reg[g]) : DEN_W'(den1_reg[g]);
            // round to nearest: (2|n| + |d|) / (2|d|), n scaled to Q14
            n2_next[g]   = (REM_W'(nmag) << (NORM_FRAC + 1)) + REM_W'(dmag);
            d2_next[g]   = DVS_W'(dmag) << 1;
            neg2_next[g] = num1_reg[g][NUM_W-1] ^ den1_reg[g][DEN_W-1] ^ (g == 0);
        end
    end

    for (genvar h = 0; h < 2; h++) begin : g_an2
        always_comb begin
            logic signed [AZW-1:0] z;
            z = asgn1_reg[h] ? -AZW'(amod1_reg[h]) : AZW'(amod1_reg[h]);
            if (z < 0) z = z + AZW'(FULL_A);
            if (z >= AZW'(HALF_A)) z = z - AZW'(FULL_A);
            flip2_next[h] = 1'b0;
            if (z > AZW'(QUARTER_A)) begin
                z = z - AZW'(HALF_A);
                flip2_next[h] = 1'b1;
            end else if (z < -AZW'(QUARTER_A)) begin
                z = z + AZW'(HALF_A);
                flip2_next[h] = 1'b1;
            end
            za2_next[h] = z;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int g = 0; g < 3; g++) begin
                n2_reg[g]   <= n2_next[g];
                d2_reg[g]   <= d2_next[g];
                neg2_reg[g] <= neg2_next[g];
            end
            for (int h = 0; h < 2; h++) begin
                za2_reg[h]   <= za2_next[h];
                flip2_reg[h] <= flip2_next[h];
            end
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    div_lane_t            div_reg  [DIV_QB+1][3];
    div_lane_t            div_next [DIV_QB][3];
    logic signed [ZW-1:0] dz_reg   [DIV_QB+1][2];
    logic                 dflip_reg[DIV_QB+1][2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int g = 0; g < 3; g++) begin
                div_reg[0][g].rem <= n2_reg[g];
                div_reg[0][g].dvs <= d2_reg[g];
                div_reg[0][g].quo <= '0;
                div_reg[0][g].neg <= neg2_reg[g];
                // quotient too large for the kept bits: saturates
                div_reg[0][g].ovf <= n2_reg[g] >= (REM_W'(d2_reg[g]) << DIV_QB);
            end
            for (int h = 0; h < 2; h++) begin
                dz_reg[0][h]    <= ZW'(za2_reg[h]) <<< ZSH;
                dflip_reg[0][h] <= flip2_reg[h];
            end
        end
    end

    for (genvar k = 0; k < DIV_QB; k++) begin : g_div
        for (genvar g = 0; g < 3; g++) begin : g_dax
            always_comb begin
                logic [REM_W-1:0] trial;
                trial = REM_W'(div_reg[k][g].dvs) << (DIV_QB - 1 - k);
                div_next[k][g] = div_reg[k][g];
                if (div_reg[k][g].rem >= trial) begin
                    div_next[k][g].rem = div_reg[k][g].rem - trial;
                    div_next[k][g].quo[DIV_QB-1-k] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int g = 0; g < 3; g++) div_reg[k+1][g] <= div_next[k][g];
                for (int h = 0; h < 2; h++) begin
                    dz_reg[k+1][h]    <= dz_reg[k][h];
                    dflip_reg[k+1][h] <= dflip_reg[k][h];
                end
            end
        end
    end

    function automatic logic signed [NORM_W-1:0] norm_sat(input div_lane_t l);
        logic [NORM_W-1:0]        neg_q;
        logic signed [NORM_W-1:0] res;
        neg_q = ~l.quo + 1'b1;
        if (l.neg)
            res = (l.ovf || l.quo > NEG_LIM) ? NORM_MIN : signed'(neg_q);
        else
            res = (l.ovf || l.quo > POS_LIM) ? NORM_MAX : signed'(l.quo);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // saturation, then rotation CORDIC for sin/cos of roll and pitch
    // ------------------------------------------------------------------
    rot_lane_t rot_reg  [CORDIC_STAGES+1][2];
    rot_lane_t rot_next [CORDIC_STAGES][2];
    norm_t     rn_reg   [CORDIC_STAGES+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            rn_reg[0].x <= norm_sat(div_reg[DIV_QB][0]);
            rn_reg[0].y <= norm_sat(div_reg[DIV_QB][1]);
            rn_reg[0].z <= norm_sat(div_reg[DIV_QB][2]);
            for (int h = 0; h < 2; h++) begin
                rot_reg[0][h].x    <= CORDIC_GAIN;
                rot_reg[0][h].y    <= '0;
                rot_reg[0][h].z    <= dz_reg[DIV_QB][h];
                rot_reg[0][h].flip <= dflip_reg[DIV_QB][h];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
        for (genvar h = 0; h < 2; h++) begin : g_rh
            always_comb begin
                rot_next[i][h] = rot_reg[i][h];
                if (!rot_reg[i][h].z[ZW-1]) begin
                    rot_next[i][h].x = rot_reg[i][h].x - (rot_reg[i][h].y >>> i);
                    rot_next[i][h].y = rot_reg[i][h].y + (rot_reg[i][h].x >>> i);
                    rot_next[i][h].z = rot_reg[i][h].z - atan_deg(i);
                end else begin
                    rot_next[i][h].x = rot_reg[i][h].x + (rot_reg[i][h].y >>> i);
                    rot_next[i][h].y = rot_reg[i][h].y - (rot_reg[i][h].x >>> i);
                    rot_next[i][h].z = rot_reg[i][h].z + atan_deg(i);
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rot_reg[i+1][0] <= rot_next[i][0];
                rot_reg[i+1][1] <= rot_next[i][1];
                rn_reg[i+1]     <= rn_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // undo the half-turn fold, then the tilt products
    // ------------------------------------------------------------------
    logic signed [CW-1:0] cr_reg, sr_reg, cp_reg, sp_reg;
    norm_t                fn_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cr_reg <= rot_reg[CORDIC_STAGES][0].flip ? -rot_reg[CORDIC_STAGES][0].x
                                                     : rot_reg[CORDIC_STAGES][0].x;
            sr_reg <= rot_reg[CORDIC_STAGES][0].flip ? -rot_reg[CORDIC_STAGES][0].y
                                                     : rot_reg[CORDIC_STAGES][0].y;
            cp_reg <= rot_reg[CORDIC_STAGES][1].flip ? -rot_reg[CORDIC_STAGES][1].x
                                                     : rot_reg[CORDIC_STAGES][1].x;
            sp_reg <= rot_reg[CORDIC_STAGES][1].flip ? -rot_reg[CORDIC_STAGES][1].y
                                                     : rot_reg[CORDIC_STAGES][1].y;
            fn_reg <= rn_reg[CORDIC_STAGES];
        end
    end

    logic signed [2*CW-1:0]      srsp_p_reg, srcp_p_reg;
    logic signed [NORM_W+CW-1:0] mxcp_reg, mzsp_reg, mycr_reg;
    norm_t                       p1n_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            srsp_p_reg <= sr_reg * sp_reg;
            srcp_p_reg <= sr_reg * cp_reg;
            mxcp_reg   <= fn_reg.x * cp_reg;
            mzsp_reg   <= fn_reg.z * sp_reg;
            mycr_reg   <= fn_reg.y * cr_reg;
            p1n_reg    <= fn_reg;
        end
    end

    logic signed [CW-1:0]        srsp, srcp;
    logic signed [NORM_W+CW-1:0] mxss_reg, mzsc_reg, mxcp2_reg, mzsp2_reg, mycr2_reg;
    norm_t                       p2n_reg;

    // floor back to Q30
    assign srsp = srsp_p_reg[CQ+CW-1:CQ];
    assign srcp = srcp_p_reg[CQ+CW-1:CQ];

    always_ff @(posedge aclk) begin
        if (adv) begin
            mxss_reg  <= p1n_reg.x * srsp;
            mzsc_reg  <= p1n_reg.z * srcp;
            mxcp2_reg <= mxcp_reg;
            mzsp2_reg <= mzsp_reg;
            mycr2_reg <= mycr_reg;
            p2n_reg   <= p1n_reg;
        end
    end

    logic signed [VW-1:0] xh_reg, yh_reg;
    norm_t                p3n_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            xh_reg  <= VW'(mxcp2_reg) + VW'(mzsp2_reg);
            yh_reg  <= VW'(mxss_reg) + VW'(mycr2_reg) - VW'(mzsc_reg);
            p3n_reg <= p2n_reg;
        end
    end

    // ------------------------------------------------------------------
    // vectoring CORDIC for atan2(yh, xh)
    // ------------------------------------------------------------------
    vec_lane_t vec_reg  [CORDIC_STAGES+1];
    vec_lane_t vec_next [CORDIC_STAGES];
    norm_t     vn_reg   [CORDIC_STAGES+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            vec_reg[0].zero <= (xh_reg == '0) && (yh_reg == '0);
            if (xh_reg[VW-1]) begin
                vec_reg[0].x <= -xh_reg;
                vec_reg[0].y <= -yh_reg;
                vec_reg[0].z <= DEG_180;
            end else begin
                vec_reg[0].x <= xh_reg;
                vec_reg[0].y <= yh_reg;
                vec_reg[0].z <= '0;
            end
            vn_reg[0] <= p3n_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
        always_comb begin
            vec_next[i] = vec_reg[i];
            if (!vec_reg[i].y[VW-1]) begin
                vec_next[i].x = vec_reg[i].x + (vec_reg[i].y >>> i);
                vec_next[i].y = vec_reg[i].y - (vec_reg[i].x >>> i);
                vec_next[i].z = vec_reg[i].z + atan_deg(i);
            end else begin
                vec_next[i].x = vec_reg[i].x - (vec_reg[i].y >>> i);
                vec_next[i].y = vec_reg[i].y + (vec_reg[i].x >>> i);
                vec_next[i].z = vec_reg[i].z - atan_deg(i);
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                vec_reg[i+1] <= vec_next[i];
                vn_reg[i+1]  <= vn_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // output: round to the heading unit, wrap into [0, 360)
    // ------------------------------------------------------------------
    logic [HEAD_W-1:0] head_next, head_reg;
    norm_t             on_reg;

    always_comb begin
        logic signed [ZW-1:0] hz;
        logic signed [ZW-1:0] hr;
        hz = vec_reg[CORDIC_STAGES].zero ? '0 : vec_reg[CORDIC_STAGES].z;
        hr = (hz + (ZW'(1) <<< (ZSH - 1))) >>> ZSH;
        if (hr < 0)
            hr = hr + ZW'(FULL_A);
        else if (hr >= ZW'(FULL_A))
            hr = hr - ZW'(FULL_A);
        head_next = hr[HEAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            head_reg <= head_next;
            on_reg   <= vn_reg[CORDIC_STAGES];
        end
    end

    assign m_tdata = {{M_PAD{1'b0}}, head_reg, on_reg};

endmodule

>>> tb/magnetometer_tilt_compensated_heading_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_tilt_compensated_heading_core_tb - compass heading core bench
// Streams magnetometer samples and tilt angles into the core under several
// calibration windows and random stalls on both sides. Each result word is
// checked against an in-bench fixed-point model of the normalizer, the two
// CORDIC sections and the heading wrap.
// ----------------------------------------------------------------------------
module magnetometer_tilt_compensated_heading_core_tb
    import mtch_pkg::*;
();

    localparam int  STAGES     = 16;
    localparam int  FRAC       = 8;
    localparam int  LATENCY    = 61;
    localparam int  STALL_LIM  = 5000;
    localparam int  REG_UNUSED = 6;
    localparam longint DEG1    = 64'sd1048576;
    localparam longint GAIN    = 64'sd652032874;

    typedef struct {
        logic signed [RAW_W-1:0] rx, ry, rz;
        logic signed [ANG_W-1:0] roll, pitch;
    } sample_t;

    typedef struct {
        logic [NORM_W-1:0] nx, ny, nz;
        logic [HEAD_W-1:0] head;
    } heading_t;

    logic                 aclk, aresetn;
    logic                 s_tvalid, s_tready, m_tvalid, m_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel, penable, pwrite, pready;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata, prdata;

    magnetometer_tilt_compensated_heading_core dut (.*);

    longint   atan_lut [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750059, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };
    longint   cal [NUM_REGS];
    sample_t  sample_q [$];
    heading_t heading_q [$];
    sample_t  cur_sample;
    int       send_idle_pct, recv_idle_pct, calm;
    bit       send_hold;
    int       mismatches, stall_cycles;

    function automatic longint div_nearest(longint n, longint d);
        longint an, ad, q;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint scale_axis(longint t, longint lo, longint hi, bit neg);
        longint q;
        if (hi == lo) q = (t - lo) * 16384;
        else q = div_nearest((2 * t - hi - lo) * 16384, hi - lo);
        if (neg) q = -q;
        if (q > 262143) q = 262143;
        if (q < -262144) q = -262144;
        return q;
    endfunction

    function automatic void rotate_angle(longint a, output longint c, output longint s);
        longint full, z, x, y, nx;
        bit flip;
        full = 360 * DEG1;
        z = (a * (64'sd1 << (20 - FRAC))) % full;
        x = GAIN; y = 0; flip = 0;
        if (z < 0) z += full;
        if (z >= 180 * DEG1) z -= full;
        if (z > 90 * DEG1) begin
            z -= 180 * DEG1; flip = 1;
        end else if (z < -90 * DEG1) begin
            z += 180 * DEG1; flip = 1;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, nx;
        if (x == 0 && y == 0) return 0;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 180 * DEG1;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic heading_t compass(sample_t smp);
        heading_t r;
        longint mx, my, mz, cr, sr, cp, sp, srsp, srcp, xh, yh, h, full;
        mx = scale_axis(longint'(smp.rx), cal[REG_X_MIN], cal[REG_X_MAX], 1);
        my = scale_axis(-longint'(smp.ry), cal[REG_Y_MIN], cal[REG_Y_MAX], 0);
        mz = scale_axis(longint'(smp.rz), cal[REG_Z_MIN], cal[REG_Z_MAX], 0);
        rotate_angle(longint'(smp.roll), cr, sr);
        rotate_angle(longint'(smp.pitch), cp, sp);
        srsp = (sr * sp) >>> 30;
        srcp = (sr * cp) >>> 30;
        xh = mx * cp + mz * sp;
        yh = mx * srsp + my * cr - mz * srcp;
        h = vector_angle(xh, yh);
        h = (h + (64'sd1 << (19 - FRAC))) >>> (20 - FRAC);
        full = 360 * (64'sd1 << FRAC);
        h = h % full;
        if (h < 0) h += full;
        r.nx = mx[NORM_W-1:0]; r.ny = my[NORM_W-1:0]; r.nz = mz[NORM_W-1:0];
        r.head = h[HEAD_W-1:0];
        return r;
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // driver: a new word is offered once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            calm     <= 0;
        end else begin
            if (s_tvalid && s_tready)
                heading_q.push_back(compass(cur_sample));
            if (!s_tvalid || s_tready) begin
                if (calm > 0) calm <= calm - 1;
                else if ($urandom_range(199) == 0) calm <= 40;
                if (sample_q.size() > 0 && !send_hold &&
                    (calm > 0 || $urandom_range(99) >= send_idle_pct)) begin
                    cur_sample = sample_q.pop_front();
                    s_tdata <= {6'd0, cur_sample.pitch, cur_sample.roll,
                                cur_sample.rz, cur_sample.ry, cur_sample.rx};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        heading_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (calm > 0) || ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                got.nx = m_tdata[18:0];  got.ny = m_tdata[37:19];
                got.nz = m_tdata[56:38]; got.head = m_tdata[73:57];
                if (heading_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", m_tdata);
                end else begin
                    want = heading_q.pop_front();
                    if (got.nx !== want.nx || got.ny !== want.ny ||
                        got.nz !== want.nz || got.head !== want.head) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp x=%h y=%h z=%h hdg=%h got x=%h y=%h z=%h hdg=%h",
                                     want.nx, want.ny, want.nz, want.head,
                                     got.nx, got.ny, got.nz, got.head);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIM) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic reg_write(int idx, longint val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'(4 * idx); pwdata <= APB_DW'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0;
        if (idx < NUM_REGS) cal[idx] = longint'($signed(val[15:0]));
    endtask

    task automatic set_window(longint xl, xh, yl, yh, zl, zh);
        reg_write(REG_X_MIN, xl); reg_write(REG_X_MAX, xh);
        reg_write(REG_Y_MIN, yl); reg_write(REG_Y_MAX, yh);
        reg_write(REG_Z_MIN, zl); reg_write(REG_Z_MAX, zh);
    endtask

    // checked at the falling edge, once the driver and monitor have settled
    task automatic drain();
        do @(negedge aclk);
        while (sample_q.size() > 0 || s_tvalid || heading_q.size() > 0);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    task automatic add(longint x, y, z, r, p);
        sample_t smp;
        smp.rx = RAW_W'(x); smp.ry = RAW_W'(y); smp.rz = RAW_W'(z);
        smp.roll = ANG_W'(r); smp.pitch = ANG_W'(p);
        sample_q.push_back(smp);
    endtask

    function automatic longint pick_raw(longint lo, longint hi);
        longint a, b, v;
        a = (lo < hi ? lo : hi) - 300;
        b = (lo < hi ? hi : lo) + 300;
        if (a < -32768) a = -32768;
        if (b > 32767) b = 32767;
        if ($urandom_range(99) < 30) return longint'($signed(16'($urandom)));
        v = a + $urandom_range(int'(b - a));
        return v;
    endfunction

    function automatic longint pick_angle();
        if ($urandom_range(99) < 15) return longint'($signed(17'($urandom)));
        return longint'($urandom_range(92160)) - 46080;
    endfunction

    task automatic add_random(int n);
        for (int i = 0; i < n; i++) begin
            // Y is flipped before the window is applied
            add(pick_raw(cal[REG_X_MIN], cal[REG_X_MAX]),
                -pick_raw(cal[REG_Y_MIN], cal[REG_Y_MAX]),
                pick_raw(cal[REG_Z_MIN], cal[REG_Z_MAX]),
                pick_angle(), pick_angle());
            if (sample_q[$].ry == 16'sh8000 && $urandom_range(1)) sample_q[$].ry = 16'sh7fff;
        end
    endtask

    initial begin
        aresetn = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        send_idle_pct = 10; recv_idle_pct = 74; send_hold = 0;
        mismatches = 0; stall_cycles = 0;
        for (int i = 0; i < NUM_REGS; i++) cal[i] = CAL_RESET[i];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset window first, then extremes
        add(0, 0, 0, 0, 0);
        add(1650, -1550, 5250, 0, 0);               // zero horizontal vector
        add(-32768, -32768, -32768, 46080, -46080);
        add(32767, 32767, 32767, -46080, 46080);
        add(2100, -1900, 5600, 23040, -23040);
        add(1200, -1200, 4900, 65535, -65536);
        add(1800, -1300, 5000, -65536, 65535);
        add(1500, -1700, 5500, 46079, 11520);
        add(-1, 1, -1, -1, 1);
        drain();
        set_window(-32768, 32767, -32768, 32767, -32768, 32767);
        add(-32768, 32767, 32767, 0, 23040);
        add(32767, -32768, -32768, 11520, -11520);
        add(0, 0, 0, 30000, 40000);
        drain();
        set_window(100, 100, -5, -5, 0, 0);          // equal bounds
        add(100, 5, 0, 0, 0);
        add(32767, -32768, 32767, 5000, -5000);
        add(-32768, 32767, -32768, -20000, 20000);
        add(116, 20, 15, 1000, 1000);
        drain();
        set_window(32767, -32768, 2000, -2000, 900, 100); // reversed bounds
        reg_write(REG_UNUSED, 32'h1234);
        add(0, 0, 500, 12345, -12345);
        add(32767, -32768, 100, -46080, 46080);
        add_random(300);
        drain();

        set_window(1200, 2100, 1200, 1900, 4900, 5600);
        send_idle_pct = 74; recv_idle_pct = 10;
        add_random(150);
        // let the pipe run dry before the rest goes in
        send_hold = 1;
        do @(negedge aclk);
        while (s_tvalid || heading_q.size() > 0);
        send_hold = 0;
        add_random(150);
        drain();

        set_window(-32768 + $urandom_range(30000), $urandom_range(32767),
                   -$urandom_range(20000), $urandom_range(20000),
                   -400, 400);
        send_idle_pct = 0; recv_idle_pct = 0;
        add_random(300);
        drain();

        if (mismatches == 0 && heading_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
